### src/obb_pair_collide_resolve_core_defines.svh
// Assertion helpers shared by the collision core.
`ifndef OBB_PAIR_COLLIDE_RESOLVE_CORE_DEFINES_SVH
`define OBB_PAIR_COLLIDE_RESOLVE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OBBPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define OBBPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/obbpc_pkg.sv
// ----------------------------------------------------------------------------
// obbpc_pkg
// Shared types and codes of the box-pair collision core.
// ----------------------------------------------------------------------------
`default_nettype none
package obbpc_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int PORT_WIDTH      = 32;

  localparam logic [2:0] OP_CORNER = 3'd0;
  localparam logic [2:0] OP_AXIS   = 3'd1;
  localparam logic [2:0] OP_BOUNDS = 3'd2;
  localparam logic [2:0] OP_BODY   = 3'd3;
  localparam logic [2:0] OP_PREV   = 3'd4;
  localparam logic [2:0] OP_EVAL   = 3'd5;

  // Tag travelling alongside each product through the dot-product unit.
  typedef struct packed {
    logic v;
    logic first_comp;
    logic last_comp;
    logic first_corner;
    logic last_corner;
    logic box;
  } obbpc_tag_t;
endpackage
`default_nettype wire

### src/obbpc_mac.sv
// ----------------------------------------------------------------------------
// obbpc_mac
// Shared multiply-accumulate unit: one component product per cycle,
// summed over the three components of a corner-axis dot product.
// ----------------------------------------------------------------------------
`default_nettype none
module obbpc_mac #(
  parameter int W = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire obbpc_pkg::obbpc_tag_t  tag_i,
  input  wire logic signed [W-1:0]    op_a,
  input  wire logic signed [W-1:0]    op_b,
  output obbpc_pkg::obbpc_tag_t       tag_o,
  output logic signed [2*W+1:0]       acc_o,
  output logic                        busy_o
);
  import obbpc_pkg::*;

  obbpc_tag_t              tag_a_r, tag_b_r;
  logic signed [2*W-1:0]   prod_r;
  logic signed [2*W+1:0]   acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (tag_a_r.v) begin
      acc_nxt = (tag_a_r.first_comp ? '0 : acc_r) + (2*W+2)'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_i;
      tag_b_r <= tag_a_r;
    end
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

  assign tag_o  = tag_b_r;
  assign acc_o  = acc_r;
  assign busy_o = tag_a_r.v | tag_b_r.v;
endmodule
`default_nettype wire

### src/obb_pair_collide_resolve_core.sv
// ----------------------------------------------------------------------------
// obb_pair_collide_resolve_core
// Separating-axis collision test and push-out for one pair of boxes.
// ----------------------------------------------------------------------------
// Load transactions (corner, axis, bounds, body, previous position) give no
// result. An evaluate transaction walks 4 axes x 2 boxes x 4 corners x 3
// components = 96 products through one shared multiplier, one per cycle, then
// drains the dot-product pipeline and passes through the overlap and
// resolution states to the result strobe, with busy high throughout. The
// result is shown for one cycle on out_valid and the receiver cannot stall; it
// must take it then.
`default_nettype none
`include "obb_pair_collide_resolve_core_defines.svh"
module obb_pair_collide_resolve_core #(
  parameter int COORD_WIDTH = obbpc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic        in_box,
  input  wire logic [1:0]  in_slot,
  input  wire logic signed [obbpc_pkg::PORT_WIDTH-1:0] in_value_a,
  input  wire logic signed [obbpc_pkg::PORT_WIDTH-1:0] in_value_b,
  input  wire logic signed [obbpc_pkg::PORT_WIDTH-1:0] in_value_c,
  input  wire logic signed [obbpc_pkg::PORT_WIDTH-1:0] in_value_d,
  input  wire logic        in_static_flag,
  output logic             out_valid,
  output logic             out_collided,
  output logic signed [1:0] out_normal_first_x,
  output logic signed [1:0] out_normal_first_y,
  output logic signed [1:0] out_normal_second_x,
  output logic signed [1:0] out_normal_second_y,
  output logic             out_moved_box,
  output logic signed [obbpc_pkg::PORT_WIDTH-1:0] out_new_x,
  output logic signed [obbpc_pkg::PORT_WIDTH-1:0] out_new_y,
  output logic             out_stop_velocity
);
  import obbpc_pkg::*;

  localparam int SW = (COORD_WIDTH < PORT_WIDTH) ? COORD_WIDTH : PORT_WIDTH;
  localparam int AW = 2*SW + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_OVL   = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] j_r, j_nxt;
  logic [4:0] idx_r, idx_nxt;   // {axis, box, corner}

  logic signed [SW-1:0] corner_r [8][3];
  logic signed [SW-1:0] axis_r   [4][3];
  logic signed [SW-1:0] bnd_r    [2][4];
  logic signed [SW-1:0] pos_r    [2][3];
  logic signed [SW-1:0] prev_r   [2][2];
  logic signed [SW-1:0] mass_r   [2];
  logic                 stat_r   [2];

  logic signed [AW-1:0] mn_r [2];
  logic signed [AW-1:0] mx_r [2];
  logic                 sep_r, chk_r;
  logic signed [SW:0]   ox_r, oy_r;
  logic                 zeq_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Operand fetch for the shared multiplier.
  obbpc_tag_t           tag_issue, tag_done;
  logic signed [SW-1:0] op_a, op_b;
  logic signed [AW-1:0] acc;
  logic                 mac_busy;
  logic [2:0]           cidx;
  logic [1:0]           aidx;

  assign cidx = idx_r[2:0];
  assign aidx = {idx_r[3], idx_r[4]};

  always_comb begin
    tag_issue              = '0;
    tag_issue.v            = (state_r == ST_RUN);
    tag_issue.first_comp   = (j_r == 2'd0);
    tag_issue.last_comp    = (j_r == 2'd2);
    tag_issue.first_corner = (idx_r[1:0] == 2'd0);
    tag_issue.last_corner  = (idx_r[1:0] == 2'd3);
    tag_issue.box          = idx_r[2];
    unique case (j_r)
      2'd0: begin op_a = corner_r[cidx][0]; op_b = axis_r[aidx][0]; end
      2'd1: begin op_a = corner_r[cidx][1]; op_b = axis_r[aidx][1]; end
      default: begin op_a = corner_r[cidx][2]; op_b = axis_r[aidx][2]; end
    endcase
  end

  obbpc_mac #(.W(SW)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag_issue),
    .op_a   (op_a),
    .op_b   (op_b),
    .tag_o  (tag_done),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_EVAL) begin
          state_nxt = ST_RUN;
          j_nxt     = '0;
          idx_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (j_r == 2'd2) begin
          j_nxt   = '0;
          idx_nxt = idx_r + 5'd1;
          if (idx_r == 5'd31) state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_DRAIN: if (!mac_busy && !chk_r) state_nxt = ST_OVL;
      ST_OVL:   state_nxt = ST_RES;
      ST_RES:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Resolution arithmetic, used in ST_RES.
  logic                 lt, gt, mv, ot, collide;
  logic signed [SW+1:0] nx_w, ny_w;
  logic signed [SW-1:0] nx_s, ny_s;
  logic signed [1:0]    n0x, n0y, n1x, n1y;

  function automatic logic signed [SW-1:0] sat(input logic signed [SW+1:0] v);
    logic signed [SW-1:0] r;
    if (v[SW+1:SW-1] == 3'b000 || v[SW+1:SW-1] == 3'b111) r = v[SW-1:0];
    else if (v[SW+1]) r = {1'b1, {(SW-1){1'b0}}};
    else r = {1'b0, {(SW-1){1'b1}}};
    return r;
  endfunction

  always_comb begin
    lt      = ox_r < oy_r;
    gt      = ox_r > oy_r;
    collide = zeq_r && !sep_r;
    if (stat_r[0]) mv = 1'b1;
    else if (stat_r[1]) mv = 1'b0;
    else mv = !(mass_r[0] < mass_r[1]);
    ot = !mv;
    n0x = '0; n0y = '0; n1x = '0; n1y = '0;
    if (lt) begin
      n0x = (pos_r[0][0] < pos_r[1][0]) ? -2'sd1 : 2'sd1;
      n1x = (pos_r[1][0] < pos_r[0][0]) ? -2'sd1 : 2'sd1;
    end else begin
      n0y = (pos_r[0][1] < pos_r[1][1]) ? -2'sd1 : 2'sd1;
      n1y = (pos_r[1][1] < pos_r[0][1]) ? -2'sd1 : 2'sd1;
    end
    nx_w = (SW+2)'(pos_r[mv][0]);
    ny_w = (SW+2)'(pos_r[mv][1]);
    if (lt) begin
      nx_w = (pos_r[mv][0] < pos_r[ot][0]) ? nx_w - (SW+2)'(ox_r) : nx_w + (SW+2)'(ox_r);
    end else if (gt) begin
      ny_w = (pos_r[mv][1] < pos_r[ot][1]) ? ny_w - (SW+2)'(oy_r) : ny_w + (SW+2)'(oy_r);
    end else begin
      nx_w = (SW+2)'(prev_r[mv][0]);
      ny_w = (SW+2)'(prev_r[mv][1]);
    end
    nx_s = sat(nx_w);
    ny_s = sat(ny_w);
  end

  logic signed [SW-1:0] lo_x, hi_x, lo_y, hi_y;
  always_comb begin
    hi_x = (bnd_r[0][1] < bnd_r[1][1]) ? bnd_r[0][1] : bnd_r[1][1];
    lo_x = (bnd_r[0][0] > bnd_r[1][0]) ? bnd_r[0][0] : bnd_r[1][0];
    hi_y = (bnd_r[0][3] < bnd_r[1][3]) ? bnd_r[0][3] : bnd_r[1][3];
    lo_y = (bnd_r[0][2] > bnd_r[1][2]) ? bnd_r[0][2] : bnd_r[1][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      j_r       <= '0;
      idx_r     <= '0;
      chk_r     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      j_r       <= j_nxt;
      idx_r     <= idx_nxt;
      chk_r     <= tag_done.v && tag_done.last_comp && tag_done.last_corner && tag_done.box;
      out_valid <= (state_r == ST_RES);
    end

    // Load transactions.
    if (accept) begin
      unique case (in_operation)
        OP_CORNER: begin
          corner_r[{in_box, in_slot}][0] <= in_value_a[SW-1:0];
          corner_r[{in_box, in_slot}][1] <= in_value_b[SW-1:0];
          corner_r[{in_box, in_slot}][2] <= in_value_c[SW-1:0];
        end
        OP_AXIS: begin
          if (!in_slot[1]) begin
            axis_r[{in_box, in_slot[0]}][0] <= in_value_a[SW-1:0];
            axis_r[{in_box, in_slot[0]}][1] <= in_value_b[SW-1:0];
            axis_r[{in_box, in_slot[0]}][2] <= in_value_c[SW-1:0];
          end
        end
        OP_BOUNDS: begin
          bnd_r[in_box][0] <= in_value_a[SW-1:0];
          bnd_r[in_box][1] <= in_value_b[SW-1:0];
          bnd_r[in_box][2] <= in_value_c[SW-1:0];
          bnd_r[in_box][3] <= in_value_d[SW-1:0];
        end
        OP_BODY: begin
          pos_r[in_box][0] <= in_value_a[SW-1:0];
          pos_r[in_box][1] <= in_value_b[SW-1:0];
          pos_r[in_box][2] <= in_value_c[SW-1:0];
          mass_r[in_box]   <= in_value_d[SW-1:0];
          stat_r[in_box]   <= in_static_flag;
        end
        OP_PREV: begin
          prev_r[in_box][0] <= in_value_a[SW-1:0];
          prev_r[in_box][1] <= in_value_b[SW-1:0];
        end
        OP_EVAL: sep_r <= 1'b0;
        default: ;
      endcase
    end

    // Track projection interval per box.
    if (tag_done.v && tag_done.last_comp) begin
      if (tag_done.first_corner) begin
        mn_r[tag_done.box] <= acc;
        mx_r[tag_done.box] <= acc;
      end else begin
        if (acc < mn_r[tag_done.box]) mn_r[tag_done.box] <= acc;
        if (acc > mx_r[tag_done.box]) mx_r[tag_done.box] <= acc;
      end
    end
    if (chk_r && (mx_r[0] < mn_r[1] || mx_r[1] < mn_r[0])) sep_r <= 1'b1;

    if (state_r == ST_OVL) begin
      ox_r  <= (SW+1)'(hi_x) - (SW+1)'(lo_x);
      oy_r  <= (SW+1)'(hi_y) - (SW+1)'(lo_y);
      zeq_r <= (pos_r[0][2] == pos_r[1][2]);
    end

    if (state_r == ST_RES) begin
      out_collided        <= collide;
      out_normal_first_x  <= collide ? n0x : 2'sd0;
      out_normal_first_y  <= collide ? n0y : 2'sd0;
      out_normal_second_x <= collide ? n1x : 2'sd0;
      out_normal_second_y <= collide ? n1y : 2'sd0;
      out_moved_box       <= collide && mv;
      out_new_x           <= collide ? PORT_WIDTH'(nx_s) : '0;
      out_new_y           <= collide ? PORT_WIDTH'(ny_s) : '0;
      out_stop_velocity   <= collide && !lt && !gt;
      if (collide) begin
        pos_r[mv][0] <= nx_s;
        pos_r[mv][1] <= ny_s;
      end
    end
  end

  `OBBPC_ASSERT_IMP(a_issue_busy, clk, rst_n, tag_issue.v || mac_busy, busy, "multiplier active while idle")
  `OBBPC_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, !busy, "result strobe while busy")
  `OBBPC_ASSERT_NXT(a_eval_busy, clk, rst_n, accept && in_operation == OP_EVAL, busy, "evaluate did not start")
  `OBBPC_ASSERT_IMP(a_nocontact_zero, clk, rst_n, out_valid && !out_collided, out_new_x == '0 && out_new_y == '0 && !out_stop_velocity, "fields set without contact")
endmodule
`default_nettype wire

### sim/tb_obb_pair_collide_resolve_core.sv
// ----------------------------------------------------------------------------
// tb_obb_pair_collide_resolve_core
// Loads random box-pair scenes into the collision core and evaluates them.
// An internal predictor keeps its own copy of every store. For each accepted
// evaluate it works out the contact result, and the monitor checks each
// result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_obb_pair_collide_resolve_core;
  import obbpc_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam int ONE = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_ITEMS = 1300;

  typedef struct {
    logic [2:0] op;
    logic box;
    logic [1:0] slot;
    logic signed [31:0] a, b, c, d;
    logic sflag;
  } box_item_t;

  typedef struct {
    logic collided;
    logic signed [1:0] n0x, n0y, n1x, n1y;
    logic moved;
    logic signed [31:0] nx, ny;
    logic stop;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_operation = '0;
  logic in_box = 1'b0;
  logic [1:0] in_slot = '0;
  logic signed [31:0] in_value_a = '0, in_value_b = '0, in_value_c = '0, in_value_d = '0;
  logic in_static_flag = 1'b0;
  logic out_valid, out_collided, out_moved_box, out_stop_velocity;
  logic signed [1:0] out_normal_first_x, out_normal_first_y;
  logic signed [1:0] out_normal_second_x, out_normal_second_y;
  logic signed [31:0] out_new_x, out_new_y;

  obb_pair_collide_resolve_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_box(in_box), .in_slot(in_slot),
    .in_value_a(in_value_a), .in_value_b(in_value_b), .in_value_c(in_value_c),
    .in_value_d(in_value_d), .in_static_flag(in_static_flag),
    .out_valid(out_valid), .out_collided(out_collided),
    .out_normal_first_x(out_normal_first_x), .out_normal_first_y(out_normal_first_y),
    .out_normal_second_x(out_normal_second_x), .out_normal_second_y(out_normal_second_y),
    .out_moved_box(out_moved_box), .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_stop_velocity(out_stop_velocity)
  );

  always #1 clk = ~clk;

  // predictor copy of the block's stores
  logic signed [31:0] corner_m[8][3];
  logic signed [31:0] axis_m[4][3];
  logic signed [31:0] bounds_m[2][4];
  logic signed [31:0] pos_m[2][3];
  logic signed [31:0] prev_m[2][2];
  logic signed [31:0] mass_m[2];
  logic static_m[2];

  box_item_t pending_q[$];
  contact_t contact_q[$];
  box_item_t cur;
  int errors = 0;
  int n_sent = 0;
  int cycles = 0;

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  function automatic logic signed [67:0] dot3(int k, int ax);
    logic signed [67:0] s;
    s = corner_m[k][0] * axis_m[ax][0];
    s = s + corner_m[k][1] * axis_m[ax][1];
    s = s + corner_m[k][2] * axis_m[ax][2];
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Apply one accepted transaction to the model; queue a contact on evaluate.
  task automatic predict_contact(box_item_t it);
    contact_t r;
    int order[4];
    logic signed [67:0] mn[2], mx[2], p;
    logic signed [35:0] ox, oy, nx, ny, lo, hi;
    int mv, ot;
    bit separated;
    r = '{default: '0};
    order = '{0, 2, 1, 3};
    separated = 0;
    case (it.op)
      OP_CORNER: corner_m[it.box*4+it.slot] = '{it.a, it.b, it.c};
      OP_AXIS: if (it.slot == AXIS_X || it.slot == AXIS_Y)
        axis_m[it.box*2+it.slot] = '{it.a, it.b, it.c};
      OP_BOUNDS: bounds_m[it.box] = '{it.a, it.b, it.c, it.d};
      OP_BODY: begin
        pos_m[it.box] = '{it.a, it.b, it.c};
        mass_m[it.box] = it.d;
        static_m[it.box] = it.sflag;
      end
      OP_PREV: prev_m[it.box] = '{it.a, it.b};
      OP_EVAL: begin
        if (pos_m[0][2] != pos_m[1][2]) separated = 1;
        for (int i = 0; i < 4 && !separated; i++) begin
          for (int bx = 0; bx < 2; bx++) begin
            for (int k = 0; k < 4; k++) begin
              p = dot3(bx*4+k, order[i]);
              if (k == 0 || p < mn[bx]) mn[bx] = p;
              if (k == 0 || p > mx[bx]) mx[bx] = p;
            end
          end
          if (mx[0] < mn[1] || mx[1] < mn[0]) separated = 1;
        end
        if (!separated) begin
          hi = (bounds_m[0][1] < bounds_m[1][1]) ? bounds_m[0][1] : bounds_m[1][1];
          lo = (bounds_m[0][0] > bounds_m[1][0]) ? bounds_m[0][0] : bounds_m[1][0];
          ox = hi - lo;
          hi = (bounds_m[0][3] < bounds_m[1][3]) ? bounds_m[0][3] : bounds_m[1][3];
          lo = (bounds_m[0][2] > bounds_m[1][2]) ? bounds_m[0][2] : bounds_m[1][2];
          oy = hi - lo;
          if (ox < oy) begin
            r.n0x = (pos_m[0][0] < pos_m[1][0]) ? -2'sd1 : 2'sd1;
            r.n1x = (pos_m[1][0] < pos_m[0][0]) ? -2'sd1 : 2'sd1;
          end else begin
            r.n0y = (pos_m[0][1] < pos_m[1][1]) ? -2'sd1 : 2'sd1;
            r.n1y = (pos_m[1][1] < pos_m[0][1]) ? -2'sd1 : 2'sd1;
          end
          if (static_m[0]) mv = 1;
          else if (static_m[1]) mv = 0;
          else if (mass_m[0] < mass_m[1]) mv = 0;
          else mv = 1;
          ot = 1 - mv;
          nx = pos_m[mv][0];
          ny = pos_m[mv][1];
          if (ox < oy) begin
            nx = (pos_m[mv][0] < pos_m[ot][0]) ? nx - ox : nx + ox;
          end else if (ox > oy) begin
            ny = (pos_m[mv][1] < pos_m[ot][1]) ? ny - oy : ny + oy;
          end else begin
            nx = prev_m[mv][0];
            ny = prev_m[mv][1];
            r.stop = 1'b1;
          end
          r.nx = sat32(nx);
          r.ny = sat32(ny);
          pos_m[mv][0] = r.nx;
          pos_m[mv][1] = r.ny;
          r.collided = 1'b1;
          r.moved = mv[0];
        end
        contact_q = {contact_q, r};
      end
      default: ;
    endcase
  endtask

  // driver: hold a transaction while busy, otherwise offer the next one or stay idle at random
  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (n_sent < N_ITEMS/3) ? 7 : (n_sent < 2*N_ITEMS/3) ? 88 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_contact(cur);
        n_sent++;
      end
      if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur = pending_q.pop_front();
        start <= 1'b1;
        in_operation <= cur.op;
        in_box <= cur.box;
        in_slot <= cur.slot;
        in_value_a <= cur.a;
        in_value_b <= cur.b;
        in_value_c <= cur.c;
        in_value_d <= cur.d;
        in_static_flag <= cur.sflag;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    contact_t e;
    if (rst_n && out_valid) begin
      if (contact_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = contact_q.pop_front();
        if (out_collided !== e.collided) report("collided", out_collided, e.collided);
        if (out_normal_first_x !== e.n0x) report("normal_first_x", out_normal_first_x, e.n0x);
        if (out_normal_first_y !== e.n0y) report("normal_first_y", out_normal_first_y, e.n0y);
        if (out_normal_second_x !== e.n1x)
          report("normal_second_x", out_normal_second_x, e.n1x);
        if (out_normal_second_y !== e.n1y)
          report("normal_second_y", out_normal_second_y, e.n1y);
        if (out_moved_box !== e.moved) report("moved_box", out_moved_box, e.moved);
        if (out_new_x !== e.nx) report("new_x", out_new_x, e.nx);
        if (out_new_y !== e.ny) report("new_y", out_new_y, e.ny);
        if (out_stop_velocity !== e.stop) report("stop_velocity", out_stop_velocity, e.stop);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add(logic [2:0] op, logic bx, logic [1:0] slot, logic signed [31:0] a,
                     logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d,
                     logic sflag);
    box_item_t it;
    it = '{op, bx, slot, a, b, c, d, sflag};
    pending_q = {pending_q, it};
  endtask

  function automatic logic signed [31:0] wild();
    case ($urandom_range(3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Load a full scene: two boxes of small integer size, mostly aligned axes.
  task automatic load_scene(bit tidy);
    int cx, cy, hx, hy, z;
    logic signed [31:0] zz;
    z = $urandom_range(2) * ONE;
    for (int bx = 0; bx < 2; bx++) begin
      cx = ($urandom_range(8) - 4) * ONE + ($urandom_range(1) ? 0 : $urandom_range(ONE));
      cy = ($urandom_range(8) - 4) * ONE;
      hx = $urandom_range(1, 3) * ONE;
      hy = $urandom_range(1, 3) * ONE;
      zz = ($urandom_range(7) == 0) ? $urandom : z;
      for (int k = 0; k < 4; k++) begin
        if (!tidy && $urandom_range(9) == 0)
          add(OP_CORNER, bx, k, wild(), wild(), wild(), $urandom, $urandom);
        else
          add(OP_CORNER, bx, k, cx + ((k & 1) ? hx : -hx), cy + ((k & 2) ? hy : -hy),
              zz, $urandom, $urandom);
      end
      if (!tidy && $urandom_range(5) == 0) begin
        add(OP_AXIS, bx, AXIS_X, wild(), wild(), wild(), $urandom, $urandom);
        add(OP_AXIS, bx, AXIS_Y, wild(), wild(), wild(), $urandom, $urandom);
      end else begin
        add(OP_AXIS, bx, AXIS_X, ONE, 0, 0, $urandom, $urandom);
        add(OP_AXIS, bx, AXIS_Y, 0, ONE, 0, $urandom, $urandom);
      end
      add(OP_BOUNDS, bx, $urandom, cx - hx, cx + hx, cy - hy, cy + hy, $urandom);
      add(OP_BODY, bx, $urandom, (!tidy && $urandom_range(5) == 0) ? wild() : cx,
          (!tidy && $urandom_range(5) == 0) ? wild() : cy, zz,
          tidy ? bx * ONE : wild(), tidy ? 1'b0 : ($urandom_range(3) == 0));
      add(OP_PREV, bx, $urandom, wild(), wild(), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    // directed: aligned scene, spare codes, ignored axis slot, z mismatch
    load_scene(1);
    add(OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
    add(OP_SPARE_LO, 1, 3, 32'sh7FFFFFFF, 32'sh80000000, -1, 0, 1);
    add(OP_SPARE_HI, 0, 0, -1, -1, -1, -1, 0);
    add(OP_AXIS, 0, 2'd3, -1, -1, -1, -1, 1);
    add(OP_BODY, 1, 0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 1);
    add(OP_EVAL, 1, 3, -1, -1, -1, -1, 1);
    while (pending_q.size() < N_ITEMS) begin
      load_scene(0);
      repeat ($urandom_range(1, 2)) add(OP_EVAL, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom);
      if ($urandom_range(3) == 0)
        add($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom);
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (pending_q.size() > 0 || start || contact_q.size() > 0);
    repeat (150) @(posedge clk);
    if (errors == 0 && contact_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+src
src/obbpc_pkg.sv
src/obbpc_mac.sv
src/obb_pair_collide_resolve_core.sv
sim/tb_obb_pair_collide_resolve_core.sv
